// ===== rtl/abib_pkg.sv =====
package abib_pkg;

    localparam int STATE_BITS     = 20;
    localparam int LABEL_BITS     = 16;
    localparam int ARC_COUNT_BITS = 24;

    localparam int PSTATE_W = STATE_BITS + 1;
    localparam int CNT_W    = ARC_COUNT_BITS + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << ARC_COUNT_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_ARC    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [1:0] {
        KIND_CONTINUE,
        KIND_START,
        KIND_FINISH
    } abib_kind_t;

    typedef struct packed {
        abib_kind_t            kind;
        logic                  order_error;
        logic                  map_valid;
        logic [PSTATE_W-1:0]   map_first_state;
        logic [PSTATE_W-1:0]   map_last_state;
    } abib_item_t;

endpackage

// ===== rtl/abib_front.sv =====
module abib_front
    import abib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [PSTATE_W-1:0]   state_count,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [STATE_BITS-1:0] s_source_state,
    input  logic [LABEL_BITS-1:0] s_lower_label,
    input  logic                  q_full,
    output logic                  push,
    output abib_item_t            push_item
);

    logic [PSTATE_W-1:0]   prev_source_reg, prev_source_next;
    logic [LABEL_BITS-1:0] prev_label_reg, prev_label_next;
    logic                  have_prev_reg, have_prev_next;

    logic [PSTATE_W-1:0] src_ext;
    logic [PSTATE_W-1:0] first_state;
    logic                src_change;
    logic                starts;
    logic                err;
    logic                range_ok;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // classification against the previous arc
    always_comb begin
        src_ext     = {1'b0, s_source_state};
        first_state = prev_source_reg + PSTATE_W'(1);
        src_change  = src_ext != prev_source_reg;
        starts      = !have_prev_reg || src_change || (s_lower_label != prev_label_reg);
        err         = src_ext >= state_count;
        push_item   = '0;
        range_ok    = 1'b0;
        if (s_command == CMD_FINISH) begin
            range_ok                 = first_state <= state_count;
            push_item.kind           = KIND_FINISH;
            push_item.order_error    = 1'b0;
            push_item.map_valid      = range_ok;
            push_item.map_first_state = range_ok ? first_state : '0;
            push_item.map_last_state  = range_ok ? state_count : '0;
        end else begin
            range_ok                 = src_change && !err && (first_state <= src_ext);
            push_item.kind           = starts ? KIND_START : KIND_CONTINUE;
            push_item.order_error    = err;
            push_item.map_valid      = range_ok;
            push_item.map_first_state = range_ok ? first_state : '0;
            push_item.map_last_state  = range_ok ? src_ext : '0;
        end
    end

    always_comb begin
        prev_source_next = prev_source_reg;
        prev_label_next  = prev_label_reg;
        have_prev_next   = have_prev_reg;
        if (push) begin
            if (s_command == CMD_FINISH) begin
                prev_source_next = '1;
                prev_label_next  = '0;
                have_prev_next   = 1'b0;
            end else begin
                prev_source_next = src_ext;
                prev_label_next  = s_lower_label;
                have_prev_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_source_reg <= '1;
            prev_label_reg  <= '0;
            have_prev_reg   <= 1'b0;
        end else begin
            prev_source_reg <= prev_source_next;
            prev_label_reg  <= prev_label_next;
            have_prev_reg   <= have_prev_next;
        end
    end

endmodule

// ===== rtl/abib_queue.sv =====
module abib_queue
    import abib_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  abib_item_t push_item,
    output logic       full,
    output logic       pop_valid,
    input  logic       pop,
    output abib_item_t pop_item
);

    abib_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < QCNT_W'(QUEUE_DEPTH)))
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/abib_back.sv =====
module abib_back
    import abib_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    input  abib_item_t          pop_item,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CNT_W-1:0]    m_block_number,
    output logic [CNT_W-1:0]    m_first_arc_position,
    output logic                m_map_valid,
    output logic [PSTATE_W-1:0] m_map_first_state,
    output logic [PSTATE_W-1:0] m_map_last_state,
    output logic                m_is_terminator,
    output logic                m_order_error
);

    logic [CNT_W-1:0]    blocks_reg, blocks_next;
    logic [CNT_W-1:0]    arcs_reg, arcs_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    block_number_reg, block_number_next;
    logic [CNT_W-1:0]    first_pos_reg, first_pos_next;
    logic                map_valid_reg, map_valid_next;
    logic [PSTATE_W-1:0] map_first_reg, map_first_next;
    logic [PSTATE_W-1:0] map_last_reg, map_last_next;
    logic                is_term_reg, is_term_next;
    logic                order_err_reg, order_err_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
    endfunction

    assign pop = pop_valid && (!out_valid_reg || m_ready);

    assign m_valid              = out_valid_reg;
    assign m_block_number       = block_number_reg;
    assign m_first_arc_position = first_pos_reg;
    assign m_map_valid          = map_valid_reg;
    assign m_map_first_state    = map_first_reg;
    assign m_map_last_state     = map_last_reg;
    assign m_is_terminator      = is_term_reg;
    assign m_order_error        = order_err_reg;

    always_comb begin
        blocks_next       = blocks_reg;
        arcs_next         = arcs_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        block_number_next = block_number_reg;
        first_pos_next    = first_pos_reg;
        map_valid_next    = map_valid_reg;
        map_first_next    = map_first_reg;
        map_last_next     = map_last_reg;
        is_term_next      = is_term_reg;
        order_err_next    = order_err_reg;
        if (pop) begin
            unique case (pop_item.kind)
                KIND_CONTINUE: begin
                    arcs_next = sat_inc(arcs_reg);
                end
                KIND_START: begin
                    out_valid_next    = 1'b1;
                    block_number_next = blocks_reg;
                    first_pos_next    = arcs_reg;
                    map_valid_next    = pop_item.map_valid;
                    map_first_next    = pop_item.map_first_state;
                    map_last_next     = pop_item.map_last_state;
                    is_term_next      = 1'b0;
                    order_err_next    = pop_item.order_error;
                    blocks_next       = sat_inc(blocks_reg);
                    arcs_next         = sat_inc(arcs_reg);
                end
                KIND_FINISH: begin
                    out_valid_next    = 1'b1;
                    block_number_next = blocks_reg;
                    first_pos_next    = arcs_reg;
                    map_valid_next    = pop_item.map_valid;
                    map_first_next    = pop_item.map_first_state;
                    map_last_next     = pop_item.map_last_state;
                    is_term_next      = 1'b1;
                    order_err_next    = 1'b0;
                    blocks_next       = '0;
                    arcs_next         = '0;
                end
                default: begin
                    arcs_next = arcs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_reg    <= '0;
            arcs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            blocks_reg    <= blocks_next;
            arcs_reg      <= arcs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        block_number_reg <= block_number_next;
        first_pos_reg    <= first_pos_next;
        map_valid_reg    <= map_valid_next;
        map_first_reg    <= map_first_next;
        map_last_reg     <= map_last_next;
        is_term_reg      <= is_term_next;
        order_err_reg    <= order_err_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        blocks_reg <= arcs_reg)
        else $error("more blocks than arcs counted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && pop_item.kind == KIND_FINISH) |=> (blocks_reg == '0 && arcs_reg == '0))
        else $error("counters not cleared after terminator");

endmodule

// ===== rtl/arc_block_index_builder.sv =====
// Arc block index builder. Takes the arcs of an arc table sorted by source state and
// then by lower label, one transfer per clock, and gives one result for every arc that
// opens a new (source, label) block: its block number, its first arc position and, when
// the source changes, the range of states that map to it. A finish transfer gives the
// terminator record (position = arc count, mapping the remaining states up to
// state_count) and clears the stream state for the next table. Arcs are taken at one
// per cycle while the queue is not full, and it drains one item per cycle while m_ready
// is high. Classification is combinational; a result is registered in the four-entry
// queue and then in the output register before it is offered on m_valid. While m_ready
// is held low, up to four items wait in the queue before s_ready drops. state_count is
// written through cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module arc_block_index_builder
    import abib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [PSTATE_W-1:0]   cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [STATE_BITS-1:0] s_source_state,
    input  logic [LABEL_BITS-1:0] s_lower_label,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CNT_W-1:0]      m_block_number,
    output logic [CNT_W-1:0]      m_first_arc_position,
    output logic                  m_map_valid,
    output logic [PSTATE_W-1:0]   m_map_first_state,
    output logic [PSTATE_W-1:0]   m_map_last_state,
    output logic                  m_is_terminator,
    output logic                  m_order_error
);

    logic [PSTATE_W-1:0] state_count_reg, state_count_next;

    logic       q_full;
    logic       push;
    abib_item_t push_item;
    logic       pop_valid;
    logic       pop;
    abib_item_t pop_item;

    assign state_count_next = cfg_wr_en ? cfg_wr_data : state_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg <= '0;
        end else begin
            state_count_reg <= state_count_next;
        end
    end

    abib_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .state_count    (state_count_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_source_state (s_source_state),
        .s_lower_label  (s_lower_label),
        .q_full         (q_full),
        .push           (push),
        .push_item      (push_item)
    );

    abib_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    abib_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .pop_valid            (pop_valid),
        .pop_item             (pop_item),
        .pop                  (pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_block_number       (m_block_number),
        .m_first_arc_position (m_first_arc_position),
        .m_map_valid          (m_map_valid),
        .m_map_first_state    (m_map_first_state),
        .m_map_last_state     (m_map_last_state),
        .m_is_terminator      (m_is_terminator),
        .m_order_error        (m_order_error)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import abib_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STATE_MAX    = (1 << STATE_BITS) - 1;
    localparam int LABEL_MAX    = (1 << LABEL_BITS) - 1;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(1) << ARC_COUNT_BITS;

    typedef struct {
        logic                  cmd;
        logic [STATE_BITS-1:0] src;
        logic [LABEL_BITS-1:0] lab;
    } arc_item_t;

    typedef struct {
        logic [CNT_W-1:0]    blk;
        logic [CNT_W-1:0]    pos;
        logic                mv;
        logic [PSTATE_W-1:0] mf;
        logic [PSTATE_W-1:0] ml;
        logic                term;
        logic                err;
    } block_rec_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [PSTATE_W-1:0]   cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_command = CMD_ARC;
    logic [STATE_BITS-1:0] s_source_state = '0;
    logic [LABEL_BITS-1:0] s_lower_label = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CNT_W-1:0]      m_block_number;
    logic [CNT_W-1:0]      m_first_arc_position;
    logic                  m_map_valid;
    logic [PSTATE_W-1:0]   m_map_first_state;
    logic [PSTATE_W-1:0]   m_map_last_state;
    logic                  m_is_terminator;
    logic                  m_order_error;

    // index state kept by the testbench
    logic [PSTATE_W-1:0]   state_count_copy = '0;
    logic [PSTATE_W-1:0]   last_source = '1;
    logic [LABEL_BITS-1:0] last_label = '0;
    logic                  have_last = 1'b0;
    logic [CNT_W-1:0]      blocks_opened = '0;
    logic [CNT_W-1:0]      arcs_counted = '0;

    arc_item_t  pending_arcs[$];
    block_rec_t due_blocks[$];
    arc_item_t  drive_item;

    bit s_took = 1'b0;
    bit m_took = 1'b0;
    bit s_burst = 1'b0;
    bit m_burst = 1'b0;
    int s_gap = 0;
    int m_stall = 0;
    int items_sent = 0;
    int fail_count = 0;
    int cycle_count = 0;

    arc_block_index_builder dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_source_state       (s_source_state),
        .s_lower_label        (s_lower_label),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_block_number       (m_block_number),
        .m_first_arc_position (m_first_arc_position),
        .m_map_valid          (m_map_valid),
        .m_map_first_state    (m_map_first_state),
        .m_map_last_state     (m_map_last_state),
        .m_is_terminator      (m_is_terminator),
        .m_order_error        (m_order_error)
    );

    always #5 aclk = ~aclk;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v < CNT_SAT) ? v + CNT_W'(1) : CNT_SAT;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic predict_block_entry(logic cmd, logic [STATE_BITS-1:0] src,
                                       logic [LABEL_BITS-1:0] lab);
        block_rec_t          rec;
        logic [PSTATE_W-1:0] first;
        logic [PSTATE_W-1:0] wide_src;
        logic                src_change;
        logic                starts;
        first = last_source + PSTATE_W'(1);
        wide_src = {1'b0, src};
        rec = '{blk: blocks_opened, pos: arcs_counted, mv: 1'b0, mf: '0, ml: '0,
                term: 1'b0, err: 1'b0};
        if (cmd == CMD_FINISH) begin
            rec.mv = first <= state_count_copy;
            rec.mf = rec.mv ? first : '0;
            rec.ml = rec.mv ? state_count_copy : '0;
            rec.term = 1'b1;
            due_blocks.push_back(rec);
            last_source = '1;
            last_label = '0;
            have_last = 1'b0;
            blocks_opened = '0;
            arcs_counted = '0;
        end else begin
            src_change = wide_src != last_source;
            starts = !have_last || src_change || lab != last_label;
            if (starts) begin
                rec.err = wide_src >= state_count_copy;
                rec.mv = src_change && !rec.err && first <= wide_src;
                rec.mf = rec.mv ? first : '0;
                rec.ml = rec.mv ? wide_src : '0;
                due_blocks.push_back(rec);
                blocks_opened = sat_inc(blocks_opened);
            end
            arcs_counted = sat_inc(arcs_counted);
            last_source = wide_src;
            last_label = lab;
            have_last = 1'b1;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_block();
        block_rec_t want;
        if (due_blocks.size() == 0) begin
            $error("result with no block expected: block_number %0d", m_block_number);
            fail_count++;
        end else begin
            want = due_blocks.pop_front();
            check_field("block_number", 32'(want.blk), 32'(m_block_number));
            check_field("first_arc_position", 32'(want.pos), 32'(m_first_arc_position));
            check_field("map_valid", 32'(want.mv), 32'(m_map_valid));
            check_field("map_first_state", 32'(want.mf), 32'(m_map_first_state));
            check_field("map_last_state", 32'(want.ml), 32'(m_map_last_state));
            check_field("is_terminator", 32'(want.term), 32'(m_is_terminator));
            check_field("order_error", 32'(want.err), 32'(m_order_error));
        end
    endtask

    // transfers on both channels, prediction and checking
    always @(posedge aclk) begin
        cycle_count++;
        s_took = aresetn && s_valid && s_ready;
        m_took = aresetn && m_valid && m_ready;
        if (s_took) begin
            predict_block_entry(s_command, s_source_state, s_lower_label);
        end
        if (m_took) begin
            check_block();
        end
    end

    // input driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_took) begin
                s_gap = draw_wait(s_burst);
                if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
            end
            if (!s_valid || s_took) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_arcs.size() > 0) begin
                    drive_item = pending_arcs.pop_front();
                    s_valid <= 1'b1;
                    s_command <= drive_item.cmd;
                    s_source_state <= drive_item.src;
                    s_lower_label <= drive_item.lab;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_took) begin
                m_stall = draw_wait(m_burst);
                if ($urandom_range(0, 39) == 0) m_burst = !m_burst;
            end
            if (m_stall > 0) begin
                m_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_arc(logic cmd, int src, int lab);
        arc_item_t it;
        it.cmd = cmd;
        it.src = STATE_BITS'(src);
        it.lab = LABEL_BITS'(lab);
        pending_arcs.push_back(it);
        items_sent++;
    endtask

    task automatic wait_idle(int tail);
        do @(posedge aclk);
        while (pending_arcs.size() != 0 || s_valid || due_blocks.size() != 0);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_state_count(int v);
        wait_idle(8);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= PSTATE_W'(v);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        state_count_copy = PSTATE_W'(v);
    endtask

    function automatic int pick_label();
        return $urandom_range(0, 1) ? $urandom_range(0, LABEL_MAX) : $urandom_range(0, 15);
    endfunction

    task automatic queue_sorted_table(int n_arcs);
        int src;
        int lab;
        int hi;
        int r;
        hi = (state_count_copy == 0) ? 8 : int'(state_count_copy) - 1;
        if (hi > STATE_MAX) hi = STATE_MAX;
        src = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, hi);
        lab = pick_label();
        for (int i = 0; i < n_arcs; i++) begin
            if (i > 0) begin
                r = $urandom_range(0, 9);
                if (r <= 2) begin
                    // same block continues
                end else if (r <= 5 && lab < LABEL_MAX) begin
                    lab = lab + $urandom_range(1, 64);
                    if (lab > LABEL_MAX) lab = LABEL_MAX;
                end else if (src < STATE_MAX) begin
                    src = src + ((r == 9) ? $urandom_range(2, 40) : 1);
                    if (src > STATE_MAX) src = STATE_MAX;
                    lab = pick_label();
                end
            end
            queue_arc(CMD_ARC, src, lab);
        end
        if ($urandom_range(0, 9) != 0) begin
            queue_arc(CMD_FINISH, $urandom_range(0, STATE_MAX), $urandom_range(0, LABEL_MAX));
        end
    endtask

    task automatic queue_noise(int n);
        int src;
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: src = $urandom_range(0, STATE_MAX);
                1: src = $urandom_range(0, 31);
                default: begin
                    src = int'(state_count_copy) - 2 + $urandom_range(0, 3);
                    if (src < 0) src = 0;
                    if (src > STATE_MAX) src = STATE_MAX;
                end
            endcase
            queue_arc(($urandom_range(0, 7) == 0) ? CMD_FINISH : CMD_ARC, src, pick_label());
        end
    endtask

    initial begin
        int pick;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_state_count(10);
        queue_arc(CMD_ARC, 0, 5);
        queue_arc(CMD_ARC, 0, 5);
        queue_arc(CMD_ARC, 0, 7);
        queue_arc(CMD_ARC, 3, 0);
        queue_arc(CMD_ARC, 3, LABEL_MAX);
        queue_arc(CMD_ARC, 2, 1);
        queue_arc(CMD_ARC, 12, 0);
        queue_arc(CMD_ARC, 12, 0);
        queue_arc(CMD_FINISH, 0, 0);
        queue_arc(CMD_ARC, 9, 3);
        queue_arc(CMD_FINISH, STATE_MAX, LABEL_MAX);
        queue_arc(CMD_FINISH, 0, 0);

        set_state_count(0);
        queue_arc(CMD_ARC, 0, 0);
        queue_arc(CMD_FINISH, 0, 0);
        queue_arc(CMD_FINISH, 0, 0);

        set_state_count(1 << STATE_BITS);
        queue_arc(CMD_ARC, STATE_MAX, LABEL_MAX);
        queue_arc(CMD_FINISH, 0, 0);
        queue_arc(CMD_ARC, 0, 0);
        queue_arc(CMD_FINISH, 0, 0);

        while (items_sent < RANDOM_ITEMS + 19) begin
            case ($urandom_range(0, 9))
                0: pick = 0;
                1: pick = 1 << STATE_BITS;
                2: pick = 1;
                3, 4, 5, 6: pick = $urandom_range(2, 64);
                default: pick = $urandom_range(0, 1 << STATE_BITS);
            endcase
            set_state_count(pick);
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 6) == 0) begin
                    queue_noise($urandom_range(1, 12));
                end else if ($urandom_range(0, 4) == 0) begin
                    queue_sorted_table($urandom_range(25, 60));
                end else begin
                    queue_sorted_table($urandom_range(1, 24));
                end
            end
        end

        wait_idle(16);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
